// ----- rtl/xcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// XOR-checked packet deframer package
// Shared widths, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package xcpd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NIBBLE_W  = 4;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [NIBBLE_W-1:0]  nibble_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MIN_HEADER = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MAX_HEADER = cfg_idx_t'(1);

	localparam byte_t MIN_HEADER_RST = byte_t'(16);
	localparam byte_t MAX_HEADER_RST = byte_t'(63);

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_GOOD      = 2'd1,
		KIND_CSUM_ERR  = 2'd2,
		KIND_SYNC_ERR  = 2'd3
	} kind_t;

endpackage

// ----- rtl/xcpd_if.sv -----
// ----------------------------------------------------------------------------
// XOR-checked packet deframer channels
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface xcpd_rx_if;
	logic               valid;
	logic               ready;
	xcpd_pkg::byte_t    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcpd_res_if;
	logic               valid;
	logic               ready;
	xcpd_pkg::kind_t    result_kind;
	xcpd_pkg::byte_t    data_byte;
	xcpd_pkg::byte_t    byte_index;
	xcpd_pkg::byte_t    packet_header;
	logic               is_midi;
	xcpd_pkg::nibble_t  cable_number;
	xcpd_pkg::byte_t    packet_length;

	modport source (output valid, output result_kind, output data_byte, output byte_index,
		output packet_header, output is_midi, output cable_number, output packet_length,
		input ready);
	modport sink   (input valid, input result_kind, input data_byte, input byte_index,
		input packet_header, input is_midi, input cable_number, input packet_length,
		output ready);
endinterface

interface xcpd_cfg_if;
	logic               valid;
	logic               ready;
	xcpd_pkg::cfg_idx_t index;
	xcpd_pkg::byte_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/xor_checked_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// XOR-checked packet deframer
// Splits received bytes into header, length, payload and checksum, passing
// payload bytes on at once and closing each packet with a status result.
// ----------------------------------------------------------------------------
// Channel | Role | Payload
// rx      | sink   | rx_byte
// res     | source | result_kind, data_byte, byte_index, packet_header,
//         |        | is_midi, cable_number, packet_length
// cfg     | sink   | index, data (always ready)
//
// One byte is accepted per cycle while the result channel does not stall; each
// passes an input register, and its result, if any, is registered in the result register.
// The parser state is updated by a single pass of logic on the input register.
// Reset puts the parser in idle and loads the default header limits.
// A stalled result holds the input register, and rx then waits.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer_top (
	input  logic           clk,
	input  logic           arst_n,
	xcpd_rx_if.sink        rx,
	xcpd_res_if.source     res,
	xcpd_cfg_if.sink       cfg
);

	logic              valid_s1;
	xcpd_pkg::byte_t   byte_s1;
	logic              adv;

	xcpd_pkg::byte_t   min_header_q;
	xcpd_pkg::byte_t   max_header_q;

	xcpd_pkg::byte_t   cur_header_q;
	logic              length_known_q;
	xcpd_pkg::byte_t   payload_length_q;
	xcpd_pkg::byte_t   payload_count_q;
	xcpd_pkg::byte_t   running_xor_q;

	xcpd_pkg::byte_t   cur_header_d;
	logic              length_known_d;
	xcpd_pkg::byte_t   payload_length_d;
	xcpd_pkg::byte_t   payload_count_d;
	xcpd_pkg::byte_t   running_xor_d;

	logic              emit;
	logic              with_packet;
	logic              midi;
	xcpd_pkg::kind_t   kind_d;
	xcpd_pkg::byte_t   index_d;

	logic              out_valid_q;
	xcpd_pkg::kind_t   kind_q;
	xcpd_pkg::byte_t   data_q;
	xcpd_pkg::byte_t   index_q;
	xcpd_pkg::byte_t   header_q;
	logic              midi_q;
	xcpd_pkg::nibble_t cable_q;
	xcpd_pkg::byte_t   length_q;

	assign adv      = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_header_q <= xcpd_pkg::MIN_HEADER_RST;
			max_header_q <= xcpd_pkg::MAX_HEADER_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				xcpd_pkg::REG_MIN_HEADER: min_header_q <= cfg.data;
				xcpd_pkg::REG_MAX_HEADER: max_header_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		cur_header_d     = cur_header_q;
		length_known_d   = length_known_q;
		payload_length_d = payload_length_q;
		payload_count_d  = payload_count_q;
		running_xor_d    = running_xor_q;
		emit             = 1'b0;
		with_packet      = 1'b1;
		kind_d           = xcpd_pkg::KIND_PAYLOAD;
		index_d          = '0;
		if (cur_header_q == '0) begin
			with_packet = 1'b0;
			if (byte_s1 < min_header_q) begin
				emit   = 1'b1;
				kind_d = xcpd_pkg::KIND_SYNC_ERR;
			end else if (byte_s1 != '0) begin
				cur_header_d    = byte_s1;
				running_xor_d   = byte_s1;
				payload_count_d = '0;
				if (byte_s1 <= max_header_q) begin
					length_known_d   = 1'b1;
					payload_length_d = {{(xcpd_pkg::BYTE_W-xcpd_pkg::NIBBLE_W){1'b0}},
						byte_s1[xcpd_pkg::BYTE_W-1 -: xcpd_pkg::NIBBLE_W]};
				end else begin
					length_known_d   = 1'b0;
					payload_length_d = '0;
				end
			end
		end else if (!length_known_q) begin
			payload_length_d = byte_s1;
			length_known_d   = 1'b1;
			running_xor_d    = running_xor_q ^ byte_s1;
		end else if (payload_count_q >= payload_length_q) begin
			emit             = 1'b1;
			kind_d           = (running_xor_q == byte_s1) ? xcpd_pkg::KIND_GOOD
				: xcpd_pkg::KIND_CSUM_ERR;
			cur_header_d     = '0;
			length_known_d   = 1'b0;
			payload_length_d = '0;
			payload_count_d  = '0;
			running_xor_d    = '0;
		end else begin
			emit            = 1'b1;
			kind_d          = xcpd_pkg::KIND_PAYLOAD;
			index_d         = payload_count_q;
			payload_count_d = payload_count_q + xcpd_pkg::byte_t'(1);
			running_xor_d   = running_xor_q ^ byte_s1;
		end
		midi = with_packet && (cur_header_q <= max_header_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_header_q     <= '0;
			length_known_q   <= 1'b0;
			payload_length_q <= '0;
			payload_count_q  <= '0;
			running_xor_q    <= '0;
		end else if (adv) begin
			cur_header_q     <= cur_header_d;
			length_known_q   <= length_known_d;
			payload_length_q <= payload_length_d;
			payload_count_q  <= payload_count_d;
			running_xor_q    <= running_xor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q   <= kind_d;
			data_q   <= byte_s1;
			index_q  <= index_d;
			header_q <= with_packet ? cur_header_q : '0;
			midi_q   <= midi;
			cable_q  <= midi ? cur_header_q[xcpd_pkg::NIBBLE_W-1:0] : '0;
			length_q <= with_packet ? payload_length_q : '0;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.result_kind   = kind_q;
	assign res.data_byte     = data_q;
	assign res.byte_index    = index_q;
	assign res.packet_header = header_q;
	assign res.is_midi       = midi_q;
	assign res.cable_number  = cable_q;
	assign res.packet_length = length_q;

`ifndef ASSERT_OFF
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		length_known_q |-> (payload_count_q <= payload_length_q))
		else $error("Payload count ran past the packet length.");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_header_q == '0) |-> (!length_known_q && payload_count_q == '0))
		else $error("Idle parser holds packet state.");

	a_sync_no_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == xcpd_pkg::KIND_SYNC_ERR) |->
		(header_q == '0 && !midi_q && length_q == '0))
		else $error("Sync error result carries packet fields.");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)))
		else $error("Input register changed while stalled.");
`endif

endmodule

// ----- tb/sv/tb_xor_checked_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// XOR-checked packet deframer testbench
// Feeds received bytes as directed and random packets under several header
// limits, predicts every result from the parser state, and compares each
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_xor_checked_packet_deframer_top;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 300;

	typedef struct packed {
		xcpd_pkg::kind_t   kind;
		xcpd_pkg::byte_t   data;
		xcpd_pkg::byte_t   idx;
		xcpd_pkg::byte_t   hdr;
		logic              midi;
		xcpd_pkg::nibble_t cable;
		xcpd_pkg::byte_t   len;
	} deframe_res_t;

	logic clk;
	logic arst_n;

	xcpd_rx_if  rx_ch ();
	xcpd_res_if res_ch ();
	xcpd_cfg_if cfg_ch ();

	xor_checked_packet_deframer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	xcpd_pkg::byte_t rx_bytes_q[$];
	deframe_res_t    due_results[$];
	deframe_res_t    got_want;

	xcpd_pkg::byte_t cfg_min_hdr;
	xcpd_pkg::byte_t cfg_max_hdr;

	xcpd_pkg::byte_t st_header;
	logic            st_len_known;
	xcpd_pkg::byte_t st_len;
	xcpd_pkg::byte_t st_count;
	xcpd_pkg::byte_t st_xor;

	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_reqs   = 0;
	int unsigned hold_done;
	int unsigned hold_left;
	int unsigned pat_age;
	logic [15:0] stall_pat;
	int unsigned gap_left;
	int unsigned burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_xor_checked_packet_deframer_top failed");
		$finish;
	end

	function automatic void deframe_byte(xcpd_pkg::byte_t b);
		deframe_res_t r;
		logic         emit;
		r    = '0;
		emit = 1'b0;
		if (st_header == 8'h00) begin
			if (b < cfg_min_hdr) begin
				r.kind = xcpd_pkg::KIND_SYNC_ERR;
				r.data = b;
				emit   = 1'b1;
			end else if (b != 8'h00) begin
				st_header = b;
				st_xor    = b;
				st_count  = '0;
				if (b <= cfg_max_hdr) begin
					st_len_known = 1'b1;
					st_len       = {4'h0, b[7:4]};
				end else begin
					st_len_known = 1'b0;
					st_len       = '0;
				end
			end
		end else if (!st_len_known) begin
			st_len       = b;
			st_len_known = 1'b1;
			st_xor       = st_xor ^ b;
		end else begin
			r.kind  = (st_count >= st_len) ? ((st_xor == b) ? xcpd_pkg::KIND_GOOD
				: xcpd_pkg::KIND_CSUM_ERR) : xcpd_pkg::KIND_PAYLOAD;
			r.data  = b;
			r.idx   = (st_count >= st_len) ? 8'h00 : st_count;
			r.hdr   = st_header;
			r.midi  = (st_header <= cfg_max_hdr);
			r.cable = r.midi ? st_header[3:0] : 4'h0;
			r.len   = st_len;
			emit    = 1'b1;
			if (st_count >= st_len) begin
				st_header    = '0;
				st_len_known = 1'b0;
				st_len       = '0;
				st_count     = '0;
				st_xor       = '0;
			end else begin
				st_count = st_count + 8'd1;
				st_xor   = st_xor ^ b;
			end
		end
		if (emit) begin
			due_results.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			err_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		end
	endfunction

	// Queues one packet and returns the number of bytes it takes on the link.
	function automatic int unsigned add_packet(xcpd_pkg::byte_t hdr, xcpd_pkg::byte_t cmd_len,
		bit corrupt);
		xcpd_pkg::byte_t csum;
		xcpd_pkg::byte_t pl;
		int unsigned     n;
		int unsigned     total;
		rx_bytes_q.push_back(hdr);
		csum  = hdr;
		total = 2;
		if (hdr <= cfg_max_hdr) begin
			n = 32'(hdr[7:4]);
		end else begin
			rx_bytes_q.push_back(cmd_len);
			csum  = csum ^ cmd_len;
			n     = 32'(cmd_len);
			total = 3;
		end
		for (int unsigned i = 0; i < n; i++) begin
			pl = xcpd_pkg::byte_t'($urandom);
			rx_bytes_q.push_back(pl);
			csum = csum ^ pl;
		end
		if (corrupt) begin
			csum = csum ^ xcpd_pkg::byte_t'($urandom_range(1, 255));
		end
		rx_bytes_q.push_back(csum);
		return total + n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
			gap_left   = 0;
			burst_left = 1;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				deframe_byte(rx_ch.rx_byte);
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (gap_left != 0 || rx_bytes_q.size() == 0) begin
					if (gap_left != 0) begin
						gap_left--;
					end
					rx_ch.valid <= 1'b0;
				end else begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= rx_bytes_q.pop_front();
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_done = 0;
			hold_left = 0;
			pat_age   = 0;
			stall_pat = '1;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					err_count++;
					$error("unexpected result transaction: kind %0d, data 0x%02h",
						res_ch.result_kind, res_ch.data_byte);
				end else begin
					got_want = due_results.pop_front();
					check_field("result_kind", got_want.kind, res_ch.result_kind);
					check_field("data_byte", got_want.data, res_ch.data_byte);
					check_field("byte_index", got_want.idx, res_ch.byte_index);
					check_field("packet_header", got_want.hdr, res_ch.packet_header);
					check_field("is_midi", got_want.midi, res_ch.is_midi);
					check_field("cable_number", got_want.cable, res_ch.cable_number);
					check_field("packet_length", got_want.len, res_ch.packet_length);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_reqs != hold_done) begin
				hold_done++;
				hold_left = LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else begin
				if (pat_age == 0) begin
					pat_age   = 48;
					stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
				end else begin
					pat_age--;
				end
				stall_pat = {stall_pat[14:0], stall_pat[15]};
				res_ch.ready <= stall_pat[0];
			end
		end
	end

	task automatic settle();
		do begin
			@(negedge clk);
		end while (rx_bytes_q.size() != 0 || rx_ch.valid || due_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(xcpd_pkg::cfg_idx_t idx, xcpd_pkg::byte_t val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		if (idx == xcpd_pkg::REG_MIN_HEADER) begin
			cfg_min_hdr = val;
		end else begin
			cfg_max_hdr = val;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(xcpd_pkg::byte_t lo_hdr, xcpd_pkg::byte_t hi_hdr,
		int unsigned n_bytes, bit long_hold);
		int unsigned     sent;
		int unsigned     pick;
		int unsigned     lo;
		int unsigned     mid;
		xcpd_pkg::byte_t hdr;
		sent = 0;
		write_reg(xcpd_pkg::REG_MIN_HEADER, lo_hdr);
		write_reg(xcpd_pkg::REG_MAX_HEADER, hi_hdr);
		@(negedge clk);
		lo  = (cfg_min_hdr == 0) ? 1 : 32'(cfg_min_hdr);
		mid = 32'(cfg_max_hdr) + 1;
		if (long_hold) begin
			hold_reqs++;
		end
		while (sent < n_bytes) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				rx_bytes_q.push_back(xcpd_pkg::byte_t'($urandom_range(0, 255)));
				sent++;
			end else if (pick == 1) begin
				rx_bytes_q.push_back((cfg_min_hdr == 0) ? 8'h00
					: xcpd_pkg::byte_t'($urandom_range(0, cfg_min_hdr - 1)));
				sent++;
			end else begin
				if ($urandom_range(0, 1) == 1 && lo <= cfg_max_hdr) begin
					hdr = xcpd_pkg::byte_t'($urandom_range(cfg_max_hdr, lo));
				end else if (mid > 255) begin
					hdr = xcpd_pkg::byte_t'($urandom_range(255, lo));
				end else begin
					hdr = xcpd_pkg::byte_t'($urandom_range(255, (lo > mid) ? lo : mid));
				end
				sent += add_packet(hdr,
					($urandom_range(0, 39) == 0) ? 8'hFF
					: xcpd_pkg::byte_t'($urandom_range(0, 6)),
					pick == 2);
			end
		end
		settle();
	endtask

	initial begin
		xcpd_pkg::byte_t p0;
		xcpd_pkg::byte_t p1;
		arst_n        = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = xcpd_pkg::REG_MIN_HEADER;
		cfg_ch.data   = '0;
		cfg_min_hdr   = xcpd_pkg::MIN_HEADER_RST;
		cfg_max_hdr   = xcpd_pkg::MAX_HEADER_RST;
		st_header     = '0;
		st_len_known  = 1'b0;
		st_len        = '0;
		st_count      = '0;
		st_xor        = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset limits: sync errors, lowest and highest headers, zero length.
		rx_bytes_q.push_back(8'h00);
		rx_bytes_q.push_back(8'h0F);
		void'(add_packet(8'h10, 8'h00, 1'b0));
		void'(add_packet(8'h3F, 8'h00, 1'b1));
		void'(add_packet(8'h40, 8'h00, 1'b0));
		void'(add_packet(8'hFF, 8'h02, 1'b0));
		settle();

		// A zero byte is ignored when the minimum header is zero.
		write_reg(xcpd_pkg::REG_MIN_HEADER, 8'h00);
		write_reg(xcpd_pkg::REG_MAX_HEADER, 8'hFF);
		@(negedge clk);
		rx_bytes_q.push_back(8'h00);
		void'(add_packet(8'h05, 8'h00, 1'b0));
		p0 = xcpd_pkg::byte_t'($urandom);
		p1 = xcpd_pkg::byte_t'($urandom);
		rx_bytes_q.push_back(8'h20);
		rx_bytes_q.push_back(p0);
		settle();

		// The maximum header moves while a packet is open.
		write_reg(xcpd_pkg::REG_MAX_HEADER, 8'h10);
		@(negedge clk);
		rx_bytes_q.push_back(p1);
		rx_bytes_q.push_back(8'h20 ^ p0 ^ p1);
		settle();

		run_phase(8'h00, 8'h00, 80, 1'b0);
		run_phase(8'hFF, 8'hFF, 60, 1'b0);
		run_phase(xcpd_pkg::MIN_HEADER_RST, xcpd_pkg::MAX_HEADER_RST, 80, 1'b1);
		run_phase(8'h00, 8'hFF, 80, 1'b0);
		run_phase(8'hFF, 8'h00, 60, 1'b0);
		run_phase(xcpd_pkg::byte_t'($urandom_range(0, 64)), xcpd_pkg::byte_t'($urandom),
			80, 1'b0);
		run_phase(xcpd_pkg::byte_t'($urandom_range(0, 64)), xcpd_pkg::byte_t'($urandom),
			80, 1'b0);

		repeat (8) @(negedge clk);
		if (err_count == 0 && due_results.size() == 0) begin
			$display("tb_xor_checked_packet_deframer_top passed");
		end else begin
			$display("tb_xor_checked_packet_deframer_top failed");
		end
		$finish;
	end

endmodule
